FILE: design/zbpa_pkg.sv
`default_nettype none
package zbpa_pkg;

  localparam int CFG_W = 14;
  localparam int CNT_W = 14;
  localparam int ZONES_DEFINED = 3;
  localparam int WORD_BITS = 32;
  localparam int WORD_SHIFT = 5;
  localparam int ADDR_W = 25;
  localparam int PAGE_SHIFT = 12;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ZONE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_RUN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

  localparam logic [2:0] REG_TOTAL_PAGES = 3'd0;
  localparam logic [2:0] REG_ZONE_COUNT = 3'd1;
  localparam logic [2:0] REG_DMA_BASE = 3'd2;
  localparam logic [2:0] REG_DMA_END = 3'd3;
  localparam logic [2:0] REG_NORMAL_BASE = 3'd4;
  localparam logic [2:0] REG_NORMAL_END = 3'd5;
  localparam logic [2:0] REG_HIGH_BASE = 3'd6;
  localparam logic [2:0] REG_HIGH_END = 3'd7;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_MARK = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLEAR = 6'b000010,
    S_SCAN = 6'b000100,
    S_CHECK = 6'b001000,
    S_MREAD = 6'b010000,
    S_MWRITE = 6'b100000
  } state_t;

endpackage
`default_nettype wire

FILE: design/zbpa_bitmap_mem.sv
`default_nettype none
module zbpa_bitmap_mem #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/zbpa_scan.sv
`default_nettype none
module zbpa_scan #(
  parameter int WA = 8,
  parameter int W = 15
) (
  input  wire logic [31:0]   word,
  input  wire logic [WA-1:0] word_index,
  input  wire logic [W-1:0]  scan_first,
  input  wire logic [W-1:0]  scan_end,
  input  wire logic [W-1:0]  run_in,
  input  wire logic [W-1:0]  count,
  output logic               found,
  output logic [W-1:0]       chosen,
  output logic [W-1:0]       run_out
);
  import zbpa_pkg::*;

  logic [WORD_BITS-1:0] free_bit;
  logic [W-1:0] page [WORD_BITS];
  logic [W-1:0] run_len [WORD_BITS];
  logic hit_block;
  logic [WORD_SHIFT-1:0] block_at;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      page[j] = W'({word_index, WORD_SHIFT'(j)});
      free_bit[j] = (page[j] >= scan_first) && (page[j] < scan_end) && !word[j];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      hit_block = 1'b0;
      block_at = '0;
      for (int i = 0; i <= j; i++) begin
        if (!free_bit[i]) begin
          hit_block = 1'b1;
          block_at = WORD_SHIFT'(i);
        end
      end
      if (hit_block) begin
        run_len[j] = W'(j) - W'(block_at);
      end else begin
        run_len[j] = run_in + W'(j + 1);
      end
    end
    found = 1'b0;
    chosen = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (run_len[j] >= count) begin
        found = 1'b1;
        chosen = page[j] - count + W'(1);
      end
    end
    run_out = run_len[WORD_BITS-1];
  end

endmodule
`default_nettype wire

FILE: design/zoned_bitmap_page_allocator_core.sv
`default_nettype none
// Sequence: a zero count is answered straight from idle; allocate scans the 32-bit bitmap
// words one by one, then marks the first word from the scan's read data and reads and
// writes each further word; mark checks the range against the zones, then reads and
// writes each word marked.
// Throughput: one item at a time; busy is high until the result strobe.
// Reset: a clearing pass zeroes all PAGE_COUNT/32 bitmap words while busy is high.
// The receiver cannot stall: done marks each result for one cycle.
module zoned_bitmap_page_allocator_core #(
  parameter int PAGE_COUNT = 8192,
  parameter int ZONE_MAX = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           opcode,
  input  wire logic [2:0]                     zone_mask,
  input  wire logic [12:0]                    start_page,
  input  wire logic [zbpa_pkg::CNT_W-1:0]     page_count,
  output logic                                done,
  output logic [zbpa_pkg::STATUS_W-1:0]       status,
  output logic [zbpa_pkg::ADDR_W-1:0]         base_address,
  output logic [zbpa_pkg::CNT_W-1:0]          free_count,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [zbpa_pkg::CFG_W-1:0]     cfg_data
);
  import zbpa_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int WA = PW - WORD_SHIFT;
  localparam int DEPTH = PAGE_COUNT / WORD_BITS;
  localparam int W = (PW + 1 > 15) ? PW + 1 : 15;
  localparam int ZN = (ZONE_MAX < ZONES_DEFINED) ? ZONE_MAX : ZONES_DEFINED;

  state_t state;
  logic [CFG_W-1:0] inst_pages;
  logic [1:0] zone_count;
  logic [CFG_W-1:0] zone_base [ZONES_DEFINED];
  logic [CFG_W-1:0] zone_end [ZONES_DEFINED];
  logic [CNT_W-1:0] avail_pages;

  logic [W-1:0] scan_first, scan_end, run, cnt, range_first, range_last, cur;
  logic [WA-1:0] word_ptr, last_word, clr_ptr;
  logic is_alloc;

  logic [1:0] live;
  logic zfound, no_zone;
  logic [W-1:0] sp, ep, epc, ep2, mlast;
  logic zhit;
  logic [W-1:0] zmax;

  logic mem_re, mem_we;
  logic [WA-1:0] mem_raddr, mem_waddr;
  logic [31:0] mem_rdata, mem_wdata, set_mask;

  logic sc_found;
  logic [W-1:0] sc_chosen, sc_run;

  assign busy = (state != S_IDLE);
  assign free_count = avail_pages;
  assign live = (32'(zone_count) > ZN) ? 2'(ZN) : zone_count;

  always_comb begin
    zfound = 1'b0;
    sp = '0;
    ep = '0;
    for (int i = 0; i < ZONES_DEFINED; i++) begin
      if (!zfound && (i < 32'(live)) && zone_mask[i]) begin
        zfound = 1'b1;
        sp = W'(zone_base[i]);
        ep = W'(zone_end[i]);
      end
    end
    epc = (ep > W'(inst_pages)) ? W'(inst_pages) : ep;
    no_zone = !zfound || (sp > W'(inst_pages)) || (sp == '0 && epc == '0);
    ep2 = (epc > W'(PAGE_COUNT)) ? W'(PAGE_COUNT) : epc;
    mlast = W'(start_page) + W'(page_count) - W'(1);
  end

  always_comb begin
    zhit = 1'b0;
    zmax = '0;
    for (int i = 0; i < ZONES_DEFINED; i++) begin
      if ((i < 32'(live)) && (W'(zone_base[i]) <= cur) && (cur <= W'(zone_end[i]))) begin
        zhit = 1'b1;
        if (W'(zone_end[i]) > zmax) begin
          zmax = W'(zone_end[i]);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      set_mask[j] = (W'({word_ptr, WORD_SHIFT'(j)}) >= range_first)
                    && (W'({word_ptr, WORD_SHIFT'(j)}) <= range_last);
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_raddr = word_ptr;
    mem_we = 1'b0;
    mem_waddr = word_ptr;
    mem_wdata = mem_rdata | set_mask;
    unique case (state)
      S_IDLE: begin
        mem_re = start && (page_count != '0) && (opcode == OP_ALLOC);
        mem_raddr = sp[PW-1:WORD_SHIFT];
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = '0;
      end
      S_SCAN: begin
        mem_re = 1'b1;
        mem_raddr = sc_found ? sc_chosen[PW-1:WORD_SHIFT] : word_ptr + WA'(1);
      end
      S_CHECK: begin
        mem_raddr = range_first[PW-1:WORD_SHIFT];
      end
      S_MREAD: begin
        mem_re = 1'b1;
      end
      S_MWRITE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  zbpa_bitmap_mem #(
    .DEPTH(DEPTH),
    .AW(WA),
    .DW(WORD_BITS)
  ) u_mem (
    .clk(clk),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata)
  );

  zbpa_scan #(
    .WA(WA),
    .W(W)
  ) u_scan (
    .word(mem_rdata),
    .word_index(word_ptr),
    .scan_first(scan_first),
    .scan_end(scan_end),
    .run_in(run),
    .count(cnt),
    .found(sc_found),
    .chosen(sc_chosen),
    .run_out(sc_run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inst_pages <= CFG_W'(8192);
      zone_count <= 2'd2;
      zone_base[0] <= CFG_W'(0);
      zone_end[0] <= CFG_W'(4095);
      zone_base[1] <= CFG_W'(4096);
      zone_end[1] <= CFG_W'(8192);
      zone_base[2] <= CFG_W'(8192);
      zone_end[2] <= CFG_W'(8192);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_PAGES: inst_pages <= cfg_data;
        REG_ZONE_COUNT: zone_count <= cfg_data[1:0];
        REG_DMA_BASE: zone_base[0] <= cfg_data;
        REG_DMA_END: zone_end[0] <= cfg_data;
        REG_NORMAL_BASE: zone_base[1] <= cfg_data;
        REG_NORMAL_END: zone_end[1] <= cfg_data;
        REG_HIGH_BASE: zone_base[2] <= cfg_data;
        REG_HIGH_END: zone_end[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_ptr <= '0;
      avail_pages <= CNT_W'(8192);
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + WA'(1);
          if (clr_ptr == WA'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cnt <= W'(page_count);
            status <= ST_OK;
            base_address <= '0;
            if (page_count == '0) begin
              status <= ST_ZERO_COUNT;
              done <= 1'b1;
            end else if (opcode == OP_ALLOC) begin
              is_alloc <= 1'b1;
              if (no_zone) begin
                status <= ST_NO_ZONE;
                done <= 1'b1;
              end else if (sp >= ep2) begin
                status <= ST_NO_RUN;
                done <= 1'b1;
              end else begin
                scan_first <= sp;
                scan_end <= ep2;
                run <= '0;
                word_ptr <= sp[PW-1:WORD_SHIFT];
                last_word <= WA'((ep2 - W'(1)) >> WORD_SHIFT);
                state <= S_SCAN;
              end
            end else begin
              is_alloc <= 1'b0;
              if (mlast >= W'(PAGE_COUNT)) begin
                status <= ST_OUTSIDE;
                done <= 1'b1;
              end else begin
                range_first <= W'(start_page);
                range_last <= mlast;
                cur <= W'(start_page);
                state <= S_CHECK;
              end
            end
          end
        end
        S_SCAN: begin
          if (sc_found) begin
            range_first <= sc_chosen;
            range_last <= sc_chosen + cnt - W'(1);
            word_ptr <= sc_chosen[PW-1:WORD_SHIFT];
            base_address <= {sc_chosen[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'(0)};
            state <= S_MWRITE;
          end else if (word_ptr == last_word) begin
            status <= ST_NO_RUN;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            run <= sc_run;
            word_ptr <= word_ptr + WA'(1);
          end
        end
        S_CHECK: begin
          if (!zhit) begin
            status <= ST_OUTSIDE;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (zmax + W'(1) > range_last) begin
            word_ptr <= range_first[PW-1:WORD_SHIFT];
            state <= S_MREAD;
          end else begin
            cur <= zmax + W'(1);
          end
        end
        S_MREAD: begin
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          if (word_ptr == range_last[PW-1:WORD_SHIFT]) begin
            avail_pages <= (W'(avail_pages) > cnt) ? avail_pages - CNT_W'(cnt) : '0;
            done <= 1'b1;
            if (!is_alloc) begin
              base_address <= '0;
            end
            state <= S_IDLE;
          end else begin
            word_ptr <= word_ptr + WA'(1);
            state <= S_MREAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_zoned_bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
module tb_zoned_bitmap_page_allocator_core;
  import zbpa_pkg::*;

  localparam int NPAGES = 8192;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0] fc;
  } page_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = 1'b0;
  logic [2:0] zone_mask = '0;
  logic [12:0] start_page = '0;
  logic [CNT_W-1:0] page_count = '0;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0] base_address;
  logic [CNT_W-1:0] free_count;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  zoned_bitmap_page_allocator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .zone_mask(zone_mask), .start_page(start_page), .page_count(page_count),
    .done(done), .status(status), .base_address(base_address),
    .free_count(free_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  bit page_used [NPAGES];
  int unsigned pages_free;
  int unsigned installed;
  int unsigned live_zones;
  int unsigned zbase [3];
  int unsigned zend [3];

  page_result_t pending_results [$];
  int errors = 0;
  int sender_idle_pct = 0;

  function automatic int find_zone(int unsigned p);
    for (int i = 0; i < 3; i++) begin
      if (i < live_zones && p >= zbase[i] && p <= zend[i]) return i;
    end
    return -1;
  endfunction

  function automatic void claim_pages(int unsigned first, int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++) begin
      if (first + k < NPAGES) page_used[first + k] = 1'b1;
    end
    pages_free = (pages_free > cnt) ? pages_free - cnt : 0;
  endfunction

  function automatic bit zbase_over(int unsigned lo);
    return lo > installed;
  endfunction

  function automatic page_result_t predict_page_op(logic op, logic [2:0] m,
                                                   int unsigned sp, int unsigned cnt);
    page_result_t r;
    int unsigned lo, hi, run, chosen;
    bit found;
    r.st = ST_OK;
    r.addr = '0;
    lo = 0;
    hi = 0;
    run = 0;
    chosen = 0;
    found = 0;
    if (cnt == 0) begin
      r.st = ST_ZERO_COUNT;
    end else if (op == OP_MARK) begin
      for (int unsigned k = 0; k < cnt; k++) begin
        if (sp + k >= NPAGES || find_zone(sp + k) < 0) begin
          r.st = ST_OUTSIDE;
          break;
        end
      end
      if (r.st == ST_OK) claim_pages(sp, cnt);
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (!found && i < live_zones && m[i]) begin
          lo = zbase[i];
          hi = zend[i];
          found = 1;
        end
      end
      if (hi > installed) hi = installed;
      if (!found || zbase_over(lo) || (lo == 0 && hi == 0)) begin
        r.st = ST_NO_ZONE;
      end else begin
        if (hi > NPAGES) hi = NPAGES;
        for (int unsigned i = lo; i < hi; i++) begin
          if (!page_used[i]) begin
            if (run == 0) chosen = i;
            run++;
            if (run == cnt) break;
          end else begin
            run = 0;
          end
        end
        if (run != cnt) begin
          r.st = ST_NO_RUN;
        end else begin
          claim_pages(chosen, cnt);
          r.addr = ADDR_W'(chosen << PAGE_SHIFT);
        end
      end
    end
    r.fc = CNT_W'(pages_free);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    page_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
        if (base_address !== e.addr)
          report_mismatch($sformatf("base_address %0h, expected %0h", base_address, e.addr));
        if (free_count !== e.fc)
          report_mismatch($sformatf("free_count %0d, expected %0d", free_count, e.fc));
      end
    end
  end

  task automatic send_item(logic op, logic [2:0] m, logic [12:0] sp, logic [CNT_W-1:0] cnt);
    if ($urandom_range(99) < sender_idle_pct) repeat ($urandom_range(1, 8)) @(negedge clk);
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    zone_mask = m;
    start_page = sp;
    page_count = cnt;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_page_op(op, m, sp, cnt));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    int unsigned v;
    v = val & 14'h3FFF;
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TOTAL_PAGES: installed = v;
      REG_ZONE_COUNT: live_zones = v & 3;
      REG_DMA_BASE: zbase[0] = v;
      REG_DMA_END: zend[0] = v;
      REG_NORMAL_BASE: zbase[1] = v;
      REG_NORMAL_END: zend[1] = v;
      REG_HIGH_BASE: zbase[2] = v;
      REG_HIGH_END: zend[2] = v;
      default: ;
    endcase
  endtask

  task automatic send_random_item();
    int unsigned sel, cnt;
    logic op;
    op = $urandom_range(1);
    sel = $urandom_range(99);
    if (sel < 70) cnt = $urandom_range(1, 4);
    else if (sel < 92) cnt = $urandom_range(5, 48);
    else if (sel < 96) cnt = 0;
    else cnt = $urandom_range(49, NPAGES);
    if (op == OP_MARK) begin
      if ($urandom_range(3) == 0)
        send_item(op, 3'($urandom), 13'($urandom_range(8150, 8191)), CNT_W'(cnt));
      else send_item(op, 3'($urandom), 13'($urandom), CNT_W'(cnt));
    end else begin
      send_item(op, 3'($urandom_range(1, 7)), 13'($urandom), CNT_W'(cnt));
    end
  endtask

  task automatic test_directed();
    send_item(OP_ALLOC, 3'd1, 13'd0, 14'd1);
    send_item(OP_ALLOC, 3'd2, 13'd0, 14'd3);
    send_item(OP_ALLOC, 3'd4, 13'd0, 14'd1);
    send_item(OP_ALLOC, 3'd0, 13'd0, 14'd1);
    send_item(OP_ALLOC, 3'd7, 13'd0, 14'd0);
    send_item(OP_MARK, 3'd0, 13'd8191, 14'd8192);
    send_item(OP_MARK, 3'd7, 13'd0, 14'd5);
    send_item(OP_MARK, 3'd0, 13'd0, 14'd1);
    send_item(OP_ALLOC, 3'd1, 13'd0, 14'd8191);
    send_item(OP_ALLOC, 3'd3, 13'd0, 14'd8192);
    send_item(OP_ALLOC, 3'd7, 13'd8191, 14'd1);
    send_item(OP_MARK, 3'd0, 13'd4095, 14'd2);
    send_item(OP_MARK, 3'd0, 13'd8191, 14'd1);
    send_item(OP_MARK, 3'd0, 13'd4096, 14'd0);
    send_item(OP_ALLOC, 3'd6, 13'd0, 14'd200);
    wait_drained();
  endtask

  task automatic test_random(int n, int idle);
    sender_idle_pct = idle;
    for (int i = 0; i < n; i++) send_random_item();
  endtask

  task automatic test_three_zones();
    write_reg(REG_TOTAL_PAGES, 6000);
    write_reg(REG_ZONE_COUNT, 3);
    write_reg(REG_DMA_BASE, 0);
    write_reg(REG_DMA_END, 1023);
    write_reg(REG_NORMAL_BASE, 1024);
    write_reg(REG_NORMAL_END, 4999);
    write_reg(REG_HIGH_BASE, 5000);
    write_reg(REG_HIGH_END, 8192);
    test_random(200, 54);
    wait_drained();
    test_random(200, 54);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TOTAL_PAGES, 0);
    send_item(OP_ALLOC, 3'd1, 13'd0, 14'd1);
    send_item(OP_ALLOC, 3'd4, 13'd0, 14'd1);
    wait_drained();
    write_reg(REG_ZONE_COUNT, 0);
    write_reg(REG_TOTAL_PAGES, 8192);
    send_item(OP_ALLOC, 3'd7, 13'd0, 14'd1);
    send_item(OP_MARK, 3'd7, 13'd10, 14'd1);
    wait_drained();
    write_reg(REG_ZONE_COUNT, 14'h3FFF);
    write_reg(REG_HIGH_BASE, 8192);
    write_reg(REG_DMA_BASE, 8192);
    send_item(OP_ALLOC, 3'd5, 13'd0, 14'd1);
    send_item(OP_MARK, 3'd0, 13'd8191, 14'd1);
    wait_drained();
    write_reg(REG_ZONE_COUNT, 1);
    write_reg(REG_DMA_BASE, 0);
    write_reg(REG_DMA_END, 8192);
    test_random(420, 0);
  endtask

  initial begin
    installed = 8192;
    live_zones = 2;
    zbase = '{0, 4096, 8192};
    zend = '{4095, 8192, 8192};
    pages_free = 8192;
    foreach (page_used[i]) page_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (busy) @(posedge clk);
    test_directed();
    test_random(400, 24);
    wait_drained();
    test_three_zones();
    test_register_extremes();
    wait_drained();
    if (errors == 0) begin
      $display("zoned_bitmap_page_allocator_core verification clean");
    end else begin
      $display("zoned_bitmap_page_allocator_core verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("zoned_bitmap_page_allocator_core verification failed");
    $finish;
  end

endmodule
